// ===== src/afr_pkg.sv =====
// Package for the API frame receiver: parser phase codes, the result record
// and the checksum target. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned PhaseW = 3;

  localparam logic [ByteW-1:0] SumTarget = 8'hFF;

  typedef enum logic [PhaseW-1:0] {
    PH_START    = 3'd0,
    PH_LEN_HI   = 3'd1,
    PH_LEN_LO   = 3'd2,
    PH_CONTENT  = 3'd3,
    PH_CHECKSUM = 3'd4
  } afr_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  byte_index;
    logic             frame_end;
    logic             checksum_ok;
    logic [ByteW-1:0] frame_type;
    logic [LenW-1:0]  frame_length;
  } afr_result_t;

endpackage : afr_pkg

`default_nettype wire

// ===== src/afr_if.sv =====
// Stream interfaces of the API frame receiver: received bytes in, results out.
// Depends on afr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface afr_rx_if
  import afr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : afr_rx_if

interface afr_res_if
  import afr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [LenW-1:0]  byte_index;
  logic             frame_end;
  logic             checksum_ok;
  logic [ByteW-1:0] frame_type;
  logic [LenW-1:0]  frame_length;

  modport source (output valid, output data_byte, output byte_index, output frame_end,
                  output checksum_ok, output frame_type, output frame_length,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_index, input frame_end,
                  input checksum_ok, input frame_type, input frame_length,
                  output ready);
endinterface : afr_res_if

`default_nettype wire

// ===== src/afr_deframer.sv =====
// Frame parser state and per-byte result logic of the API frame receiver.
// Depends on afr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afr_deframer
  import afr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             byte_valid_i,
  input  wire logic [ByteW-1:0] byte_i,
  output logic                  res_valid_o,
  output afr_result_t           res_o
);

  afr_phase_e       phase_q, phase_d;
  logic [LenW-1:0]  length_q, length_d;
  logic [LenW-1:0]  count_q, count_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] type_q, type_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      length_q <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      type_q   <= '0;
    end else if (byte_valid_i) begin
      phase_q  <= phase_d;
      length_q <= length_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      type_q   <= type_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    length_d    = length_q;
    count_d     = count_q;
    sum_d       = sum_q;
    type_d      = type_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (phase_q)
      PH_LEN_HI: begin
        length_d = {byte_i, {ByteW{1'b0}}};
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_d = {length_q[LenW-1:ByteW], byte_i};
        count_d  = '0;
        sum_d    = '0;
        type_d   = '0;
        phase_d  = (length_d == '0) ? PH_CHECKSUM : PH_CONTENT;
      end
      PH_CONTENT: begin
        // latch the frame type on the first content byte
        if (count_q == '0) begin
          type_d = byte_i;
        end
        sum_d       = sum_q + byte_i;
        count_d     = count_q + 1'b1;
        res_valid_o = 1'b1;
        res_o.data_byte  = byte_i;
        res_o.byte_index = count_q;
        if (count_d == length_q) begin
          phase_d = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        sum_d             = sum_q + byte_i;
        res_valid_o       = 1'b1;
        res_o.frame_end   = 1'b1;
        res_o.checksum_ok = (sum_d == SumTarget);
        phase_d           = PH_START;
      end
      default: begin
        phase_d = PH_LEN_HI;
      end
    endcase

    res_o.frame_type   = type_d;
    res_o.frame_length = length_d;
  end

endmodule : afr_deframer

`default_nettype wire

// ===== src/api_frame_receiver.sv =====
// A byte that yields a result passes through the byte register and then the result
// register to res_o, as long as the result register is free.
// Throughput: one byte per cycle unless res_o stalls; parser updates once per byte.
// Start and length bytes produce no result and leave the output untouched.
// Back-pressure: the byte register and the result register each hold one item.
// Reset (rst_ni low, asynchronous): parser takes the next byte as a start byte,
// counters clear, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the API frame receiver; instantiates afr_deframer.
// Depends on afr_pkg and the afr_rx_if / afr_res_if interfaces.
module api_frame_receiver
  import afr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  afr_rx_if.sink     rx_i,
  afr_res_if.source  res_o
);

  // Byte register: holds the accepted byte until the parser consumes it.
  logic             byte_valid_q;
  logic [ByteW-1:0] byte_q;

  // Result register: holds a finished result until the sink takes it.
  logic        out_valid_q;
  afr_result_t out_q;

  logic        advance;     // byte register hands its byte to the parser
  logic        par_valid;
  afr_result_t par_res;

  // The parser consumes the held byte whenever the result register can take
  // a new value (or the byte yields no result, which still needs the slot free
  // to keep the rule simple and the order intact).
  assign advance    = byte_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !byte_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      byte_valid_q <= rx_i.valid;
    end
  end

  // Payload: capture on every transfer, no reset needed.
  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  afr_deframer u_deframer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (advance),
    .byte_i       (byte_q),
    .res_valid_o  (par_valid),
    .res_o        (par_res)
  );

  // Advance the result register when empty or drained; drop nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || res_o.ready) begin
      out_valid_q <= advance && par_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && par_valid) begin
      out_q <= par_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.data_byte    = out_q.data_byte;
  assign res_o.byte_index   = out_q.byte_index;
  assign res_o.frame_end    = out_q.frame_end;
  assign res_o.checksum_ok  = out_q.checksum_ok;
  assign res_o.frame_type   = out_q.frame_type;
  assign res_o.frame_length = out_q.frame_length;

`ifndef SYNTHESIS
  // Frame-end results carry zero data and zero index.
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_end) |-> (res_o.data_byte == '0 && res_o.byte_index == '0))
    else $error("frame-end result carries content fields");

  // A good checksum is only reported on a frame-end result.
  a_ok_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.checksum_ok) |-> res_o.frame_end)
    else $error("checksum_ok set on a content result");

  // A held byte that cannot advance stays in the byte register.
  a_byte_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_q && !advance) |=> (byte_valid_q && $stable(byte_q)))
    else $error("stalled byte lost from byte register");
`endif

endmodule : api_frame_receiver

`default_nettype wire
